>>> rtl/s2a_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s2a_pkg
// Shared types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package s2a_pkg;

    localparam int VALUE_W     = 32;
    localparam int NUM_DIGITS  = 10;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int DIG_IDX_W   = 4;
    localparam int NUM_DAB     = 4;                  // shift-add-3 stages
    localparam int BITS_PER_DAB = VALUE_W / NUM_DAB; // bits consumed per stage

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // Item as it travels down the conversion pipeline.
    typedef struct packed {
        logic                 neg;
        logic [VALUE_W-1:0]   bin;   // remaining magnitude bits, MSB first
        logic [BCD_W-1:0]     bcd;   // digits built so far
    } t_dab;

endpackage : s2a_pkg
`default_nettype wire

>>> rtl/s2a_dabble_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s2a_dabble_stage
// One register stage of the binary to BCD converter: shifts a fixed number of
// magnitude bits into the BCD digits, with add-3 correction before each shift.
// ----------------------------------------------------------------------------
module s2a_dabble_stage (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire s2a_pkg::t_dab i_data,
    output logic              o_ready,
    output logic              o_valid,
    output s2a_pkg::t_dab     o_data,
    input  wire logic         i_ready
);
    import s2a_pkg::*;

    logic r_valid;
    t_dab r_data;
    t_dab n_data;

    always_comb begin
        t_dab t;
        t = i_data;
        for (int s = 0; s < BITS_PER_DAB; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (t.bcd[d*4 +: 4] >= 4'd5) begin
                    t.bcd[d*4 +: 4] = t.bcd[d*4 +: 4] + 4'd3;
                end
            end
            {t.bcd, t.bin} = {t.bcd[BCD_W-2:0], t.bin, 1'b0};
        end
        n_data = t;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule : s2a_dabble_stage
`default_nettype wire

>>> rtl/s2a_serializer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s2a_serializer
// Takes a converted number and sends its text one character per cycle:
// optional minus sign, then digits from the leading nonzero one down.
// ----------------------------------------------------------------------------
module s2a_serializer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire s2a_pkg::t_dab i_data,
    output logic               o_ready,
    output logic               o_valid,
    output logic [7:0]         o_character,
    output logic               o_last
);
    import s2a_pkg::*;

    logic                 r_act;
    logic                 r_sign;
    logic [DIG_IDX_W-1:0] r_idx;
    logic [BCD_W-1:0]     r_bcd;
    logic [DIG_IDX_W-1:0] n_top;
    logic [3:0]           cur_digit;
    logic                 load;

    // Highest nonzero digit; zero gives index 0 so a lone '0' is sent.
    always_comb begin
        n_top = '0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (i_data.bcd[d*4 +: 4] != 4'd0) begin
                n_top = DIG_IDX_W'(d);
            end
        end
    end

    always_comb begin
        cur_digit = r_bcd[3:0];
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_idx == DIG_IDX_W'(d)) begin
                cur_digit = r_bcd[d*4 +: 4];
            end
        end
    end

    assign o_ready     = !r_act || (!r_sign && r_idx == '0);
    assign load        = i_valid && o_ready;
    assign o_valid     = r_act;
    assign o_character = r_sign ? ASCII_MINUS : (ASCII_ZERO + {4'b0000, cur_digit});
    assign o_last      = r_act && !r_sign && r_idx == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (load) begin
            r_act <= 1'b1;
        end else if (o_last) begin
            r_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sign <= i_data.neg;
            r_idx  <= n_top;
            r_bcd  <= i_data.bcd;
        end else if (r_act) begin
            if (r_sign) begin
                r_sign <= 1'b0;
            end else if (r_idx != '0) begin
                r_idx <= r_idx - 1'b1;
            end
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> r_idx < DIG_IDX_W'(NUM_DIGITS))
        else $error("digit index out of range");

    a_sign_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && i_data.neg) |=> (o_valid && o_character == ASCII_MINUS && !o_last))
        else $error("negative number must start with minus");

    a_no_idle_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act && !o_last) |=> o_valid)
        else $error("text of a number interrupted");

endmodule : s2a_serializer
`default_nettype wire

>>> rtl/signed_int_to_decimal_ascii.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text, most
// significant character first, with a last flag on the final character.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                        Transfer
// input     in         start, busy, i_value           start && !busy
// result    out        o_valid, o_character, o_last   every cycle o_valid is high
//
// Pipeline: sign/magnitude register, four shift-add-3 stages of eight bits,
// then the character serializer. After the input transfer, a number passes
// the sign/magnitude register and each stage register in turn before the
// serializer loads it and puts out its first character. A number has
// 1 to 11 characters; the serializer's single output port sets the rate.
// busy backs up through the stages while the serializer is sending.
// Reset clears all valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [s2a_pkg::VALUE_W-1:0]  i_value,
    output logic                              o_valid,
    output logic [7:0]                        o_character,
    output logic                              o_last
);
    import s2a_pkg::*;

    logic r_v0;
    t_dab r_d0;
    t_dab n_d0;
    logic rdy0;

    logic       v   [NUM_DAB+1];
    t_dab       d   [NUM_DAB+1];
    logic       rdy [NUM_DAB+1];

    // Magnitude in unsigned arithmetic so the most negative value works.
    always_comb begin
        n_d0.neg = i_value[VALUE_W-1];
        n_d0.bin = i_value[VALUE_W-1] ? (VALUE_W'(0) - i_value) : i_value;
        n_d0.bcd = '0;
    end

    assign rdy0 = !r_v0 || rdy[0];
    assign busy = !rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (rdy0) begin
            r_v0 <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && rdy0) begin
            r_d0 <= n_d0;
        end
    end

    assign v[0] = r_v0;
    assign d[0] = r_d0;

    for (genvar g = 0; g < NUM_DAB; g++) begin : g_dab
        s2a_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[g]),
            .i_data  (d[g]),
            .o_ready (rdy[g]),
            .o_valid (v[g+1]),
            .o_data  (d[g+1]),
            .i_ready (rdy[g+1])
        );
    end

    s2a_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (v[NUM_DAB]),
        .i_data      (d[NUM_DAB]),
        .o_ready     (rdy[NUM_DAB]),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_v0 && !rdy[0]))
        else $error("busy without a stalled first stage");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (r_v0 && $stable(r_d0)))
        else $error("stalled item changed");

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid)
        else $error("last flag outside a transfer");

endmodule : signed_int_to_decimal_ascii
`default_nettype wire
